FILE: rtl/rtt_pkg.sv
// Shared types, widths and codes for the retransmit tracking table.
package rtt_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int MAX_REPORTS   = 8;
  localparam int REP_W         = $clog2(MAX_REPORTS + 1);

  // Field widths
  localparam int OP_W   = 2;
  localparam int SEQ_W  = 16;
  localparam int TYPE_W = 8;
  localparam int ADDR_W = 32;
  localparam int GRP_W  = 16;
  localparam int TMR_W  = 8;
  localparam int KIND_W = 3;
  localparam int SLOT_W = 3;

  // Remainder unit: two quotient bits per cycle
  localparam int REM_CYCLES = TMR_W / 2;
  localparam int REM_CNT_W  = (REM_CYCLES > 1) ? $clog2(REM_CYCLES) : 1;

  localparam logic [SEQ_W-1:0] FIRST_SEQ = SEQ_W'(5);

  // Operations
  localparam logic [OP_W-1:0] OP_SEND = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_NEW     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RESEND  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BAD_SEQ = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ACK     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RETRY   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd6;
  localparam logic [KIND_W-1:0] KIND_DONE    = 3'd7;

  // Which result the datapath builds on an emit
  localparam logic [1:0] EMIT_ITEM   = 2'd0;
  localparam logic [1:0] EMIT_REPORT = 2'd1;
  localparam logic [1:0] EMIT_DONE   = 2'd2;

  typedef struct packed {
    logic       load;
    logic       find;
    logic       idx_inc;
    logic       rd_hit;
    logic       tick_dec;
    logic       mod_start;
    logic       emit;
    logic [1:0] emit_sel;
    logic       rep_count;
  } rtt_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            seq_zero;
    logic            idx_last;
    logic            live;
    logic            timer_one;
    logic            interval_zero;
    logic            mod_done;
    logic            rem_zero;
    logic            out_free;
    logic            rep_full;
  } rtt_sts_t;

endpackage

FILE: rtl/retransmit_tracking_table_top.sv
// Top level of the retransmit tracking table: register port, controller and datapath.
//
// The block keeps eight slots, one for each transmission sent and not yet
// acknowledged. Words come in one at a time on the input channel and each
// produces its results on the output channel, behind a result register, so
// a finished result may wait for the consumer without losing anything.
// A new send or an acknowledgement of a nonzero sequence scans the slots
// one per cycle and then emits its single result. A one-second tick visits
// the slots one per cycle while it has nothing to wait for; every live slot
// it counts down, unless it runs out or the retry interval is zero, also
// costs a remainder calculation in a shared unit that works two bits a
// cycle, and any report it emits may wait for the consumer.
// The retry and timeout settings are two 8-bit registers at byte addresses
// 0 (total timeout, reset 20) and 4 (retry interval, reset 5); they should
// only be written while the block holds no word in progress. The table is
// cleared by reset in the same cycle, so no word waits after reset.
module retransmit_tracking_table_top
  import rtt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   operation,
  input  logic [SEQ_W-1:0]  sequence_req,
  input  logic [TYPE_W-1:0] send_type,
  input  logic [ADDR_W-1:0] send_addr,
  input  logic [GRP_W-1:0]  group_count,
  // Output channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] kind,
  output logic [SEQ_W-1:0]  sequence_res,
  output logic [TYPE_W-1:0] entry_type,
  output logic [ADDR_W-1:0] entry_addr,
  output logic [GRP_W-1:0]  entry_groups,
  output logic [SLOT_W-1:0] slot,
  output logic              found,
  output logic              last
);

  // Register select is address bit 2; the bus is word aligned, so the low
  // address bits are not decoded.
  localparam logic REG_TOTAL = 1'b0;
  localparam logic REG_RETRY = 1'b1;

  logic [TMR_W-1:0] total_timeout;
  logic [TMR_W-1:0] retry_interval;
  logic             reg_write;

  rtt_cmd_t cmd;
  rtt_sts_t sts;

  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_timeout  <= TMR_W'(20);
      retry_interval <= TMR_W'(5);
    end else if (reg_write) begin
      unique case (paddr[2])
        REG_TOTAL: total_timeout  <= pwdata[TMR_W-1:0];
        REG_RETRY: retry_interval <= pwdata[TMR_W-1:0];
        default:   total_timeout  <= total_timeout;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TOTAL: prdata = {{(32-TMR_W){1'b0}}, total_timeout};
      REG_RETRY: prdata = {{(32-TMR_W){1'b0}}, retry_interval};
      default:   prdata = '0;
    endcase
  end

  // The controller owns the input handshake and decides each step; the
  // datapath holds the table and the result register and reports status.
  rtt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rtt_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .total_timeout  (total_timeout),
    .retry_interval (retry_interval),
    .operation      (operation),
    .sequence_req   (sequence_req),
    .send_type      (send_type),
    .send_addr      (send_addr),
    .group_count    (group_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .sequence_res   (sequence_res),
    .entry_type     (entry_type),
    .entry_addr     (entry_addr),
    .entry_groups   (entry_groups),
    .slot           (slot),
    .found          (found),
    .last           (last)
  );

endmodule

FILE: rtl/rtt_rem.sv
// Iterative remainder unit: timer value modulo retry interval, two bits a cycle.
module rtt_rem
  import rtt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [TMR_W-1:0] dividend,
  input  logic [TMR_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [TMR_W-1:0] rem
);

  logic [TMR_W:0]     r;
  logic [TMR_W:0]     r_next;
  logic [TMR_W-1:0]   q;
  logic [REM_CNT_W-1:0] cnt;

  function automatic logic [TMR_W:0] rem_step(input logic [TMR_W:0]   r_in,
                                               input logic             bit_in,
                                               input logic [TMR_W-1:0] d);
    logic [TMR_W:0] s;
    begin
      s = {r_in[TMR_W-1:0], bit_in};
      if (s >= {1'b0, d}) begin
        s = s - {1'b0, d};
      end
      return s;
    end
  endfunction

  assign r_next = rem_step(rem_step(r, q[TMR_W-1], divisor), q[TMR_W-2], divisor);
  assign rem    = r[TMR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == REM_CNT_W'(REM_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r <= '0;
      q <= dividend;
    end else if (busy) begin
      r <= r_next;
      q <= {q[TMR_W-3:0], 2'b00};
    end
  end

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("remainder unit restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("remainder done without a preceding busy cycle");
`endif

endmodule

FILE: rtl/rtt_datapath.sv
// Datapath: slot table, item latch, scan index, remainder unit and result register.
module rtt_datapath
  import rtt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  rtt_cmd_t          cmd,
  output rtt_sts_t          sts,
  input  logic [TMR_W-1:0]  total_timeout,
  input  logic [TMR_W-1:0]  retry_interval,
  input  logic [OP_W-1:0]   operation,
  input  logic [SEQ_W-1:0]  sequence_req,
  input  logic [TYPE_W-1:0] send_type,
  input  logic [ADDR_W-1:0] send_addr,
  input  logic [GRP_W-1:0]  group_count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] kind,
  output logic [SEQ_W-1:0]  sequence_res,
  output logic [TYPE_W-1:0] entry_type,
  output logic [ADDR_W-1:0] entry_addr,
  output logic [GRP_W-1:0]  entry_groups,
  output logic [SLOT_W-1:0] slot,
  output logic              found,
  output logic              last
);

  // Slot table
  logic [SEQ_W-1:0]  tab_seq   [TABLE_ENTRIES];
  logic [TYPE_W-1:0] tab_type  [TABLE_ENTRIES];
  logic [ADDR_W-1:0] tab_addr  [TABLE_ENTRIES];
  logic [GRP_W-1:0]  tab_grp   [TABLE_ENTRIES];
  logic [TMR_W-1:0]  tab_timer [TABLE_ENTRIES];
  logic [SEQ_W-1:0]  next_seq;

  // Latched item
  logic [OP_W-1:0]   item_op;
  logic [SEQ_W-1:0]  item_seq;
  logic [TYPE_W-1:0] item_type;
  logic [ADDR_W-1:0] item_addr;
  logic [GRP_W-1:0]  item_grp;

  // Scan state
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  hit;
  logic              hit_valid;
  logic [REP_W-1:0]  rep_cnt;
  logic              rep_timeout;

  // Single read port
  logic [IDX_W-1:0]  rd_addr;
  logic [SEQ_W-1:0]  rd_seq;
  logic [TYPE_W-1:0] rd_type;
  logic [ADDR_W-1:0] rd_addr_val;
  logic [GRP_W-1:0]  rd_grp;
  logic [TMR_W-1:0]  rd_timer;
  logic [TMR_W-1:0]  timer_dec;
  logic              find_match;
  logic              do_store;
  logic              do_clear;

  // Remainder unit
  logic              rem_busy;
  logic              rem_done;
  logic [TMR_W-1:0]  rem_val;

  // Result being built
  logic [KIND_W-1:0] res_kind;
  logic [SEQ_W-1:0]  res_seq;
  logic [TYPE_W-1:0] res_type;
  logic [ADDR_W-1:0] res_addr;
  logic [GRP_W-1:0]  res_grp;
  logic [SLOT_W-1:0] res_slot;
  logic              res_found;
  logic              res_last;

  assign rd_addr     = cmd.rd_hit ? hit : idx;
  assign rd_seq      = tab_seq[rd_addr];
  assign rd_type     = tab_type[rd_addr];
  assign rd_addr_val = tab_addr[rd_addr];
  assign rd_grp      = tab_grp[rd_addr];
  assign rd_timer    = tab_timer[rd_addr];
  assign timer_dec   = rd_timer - 1'b1;

  assign find_match = (item_op == OP_SEND) ? (rd_seq == '0) : (rd_seq == item_seq);
  assign do_store   = cmd.emit && (cmd.emit_sel == EMIT_ITEM) && (item_op == OP_SEND)
                      && (item_seq == '0) && hit_valid;
  assign do_clear   = cmd.emit && (cmd.emit_sel == EMIT_ITEM) && (item_op == OP_ACK)
                      && hit_valid;

  rtt_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (timer_dec),
    .divisor  (retry_interval),
    .busy     (rem_busy),
    .done     (rem_done),
    .rem      (rem_val)
  );

  always_comb begin
    sts.op            = operation;
    sts.seq_zero      = (sequence_req == '0);
    sts.idx_last      = (idx == IDX_W'(TABLE_ENTRIES - 1));
    sts.live          = (rd_seq >= FIRST_SEQ) && (rd_timer != '0);
    sts.timer_one     = (rd_timer == TMR_W'(1));
    sts.interval_zero = (retry_interval == '0);
    sts.mod_done      = rem_done && !rem_busy;
    sts.rem_zero      = (rem_val == '0);
    sts.out_free      = !out_valid || out_ready;
    sts.rep_full      = (rep_cnt >= REP_W'(MAX_REPORTS));
  end

  // Result selection
  always_comb begin
    res_kind  = KIND_DONE;
    res_seq   = '0;
    res_type  = '0;
    res_addr  = '0;
    res_grp   = '0;
    res_slot  = '0;
    res_found = 1'b0;
    res_last  = 1'b1;
    case (cmd.emit_sel)
      EMIT_ITEM: begin
        if (item_op == OP_SEND) begin
          if (item_seq == '0) begin
            if (hit_valid) begin
              res_kind = KIND_NEW;
              res_seq  = next_seq;
              res_type = item_type;
              res_addr = item_addr;
              res_grp  = item_grp;
              res_slot = SLOT_W'(hit);
            end else begin
              res_kind = KIND_FULL;
            end
          end else begin
            res_kind = (item_seq >= FIRST_SEQ) ? KIND_RESEND : KIND_BAD_SEQ;
            res_seq  = item_seq;
          end
        end else begin
          res_kind = KIND_ACK;
          res_seq  = item_seq;
          if (hit_valid) begin
            res_type  = rd_type;
            res_addr  = rd_addr_val;
            res_grp   = rd_grp;
            res_slot  = SLOT_W'(hit);
            res_found = 1'b1;
          end
        end
      end
      EMIT_REPORT: begin
        res_kind = rep_timeout ? KIND_TIMEOUT : KIND_RETRY;
        res_seq  = rd_seq;
        res_type = rd_type;
        res_addr = rd_addr_val;
        res_grp  = rd_grp;
        res_slot = SLOT_W'(idx);
        res_last = 1'b0;
      end
      default: begin
        res_kind = KIND_DONE;
      end
    endcase
  end

  // Table and sequence counter
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        tab_seq[i]   <= '0;
        tab_type[i]  <= '0;
        tab_addr[i]  <= '0;
        tab_grp[i]   <= '0;
        tab_timer[i] <= '0;
      end
      next_seq <= FIRST_SEQ;
    end else begin
      if (do_store) begin
        tab_seq[hit]   <= next_seq;
        tab_type[hit]  <= item_type;
        tab_addr[hit]  <= item_addr;
        tab_grp[hit]   <= item_grp;
        tab_timer[hit] <= total_timeout;
        next_seq       <= (next_seq == '1) ? FIRST_SEQ : next_seq + 1'b1;
      end else if (do_clear) begin
        tab_seq[hit]   <= '0;
        tab_type[hit]  <= '0;
        tab_addr[hit]  <= '0;
        tab_grp[hit]   <= '0;
        tab_timer[hit] <= '0;
      end else if (cmd.tick_dec) begin
        tab_timer[idx] <= timer_dec;
      end
    end
  end

  // Item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op   <= operation;
      item_seq  <= sequence_req;
      item_type <= send_type;
      item_addr <= send_addr;
      item_grp  <= group_count;
    end
  end

  // Scan control state
  always_ff @(posedge clk) begin
    if (rst) begin
      idx         <= '0;
      hit         <= '0;
      hit_valid   <= 1'b0;
      rep_cnt     <= '0;
      rep_timeout <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx       <= '0;
        hit_valid <= 1'b0;
        rep_cnt   <= '0;
      end else begin
        if (cmd.idx_inc) begin
          idx <= idx + 1'b1;
        end
        if (cmd.find && find_match) begin
          hit       <= idx;
          hit_valid <= 1'b1;
        end
        if (cmd.rep_count) begin
          rep_cnt <= rep_cnt + 1'b1;
        end
        if (cmd.tick_dec) begin
          rep_timeout <= (rd_timer == TMR_W'(1));
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind         <= res_kind;
      sequence_res <= res_seq;
      entry_type   <= res_type;
      entry_addr   <= res_addr;
      entry_groups <= res_grp;
      slot         <= res_slot;
      found        <= res_found;
      last         <= res_last;
    end
  end

endmodule

FILE: rtl/rtt_ctrl.sv
// Controller state machine that sequences the table scans and result emission.
module rtt_ctrl
  import rtt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  rtt_sts_t sts,
  output rtt_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIND  = 3'd1;
  localparam logic [2:0] S_FIN   = 3'd2;
  localparam logic [2:0] S_TCHK  = 3'd3;
  localparam logic [2:0] S_TMOD  = 3'd4;
  localparam logic [2:0] S_TREP  = 3'd5;
  localparam logic [2:0] S_TDONE = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (sts.op)
            OP_SEND: state_next = sts.seq_zero ? S_FIND : S_FIN;
            OP_ACK:  state_next = sts.seq_zero ? S_FIN : S_FIND;
            OP_TICK: state_next = S_TCHK;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_FIND: begin
        cmd.find = 1'b1;
        if (sts.idx_last) begin
          state_next = S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_FIN: begin
        cmd.rd_hit = 1'b1;
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_ITEM;
          state_next   = S_IDLE;
        end
      end
      S_TCHK: begin
        if (sts.live && sts.timer_one) begin
          cmd.tick_dec = 1'b1;
          state_next   = S_TREP;
        end else if (sts.live && !sts.interval_zero) begin
          cmd.tick_dec  = 1'b1;
          cmd.mod_start = 1'b1;
          state_next    = S_TMOD;
        end else begin
          cmd.tick_dec = sts.live;
          if (sts.idx_last) begin
            state_next = S_TDONE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      S_TMOD: begin
        if (sts.mod_done) begin
          if (sts.rem_zero) begin
            state_next = S_TREP;
          end else if (sts.idx_last) begin
            state_next = S_TDONE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_TCHK;
          end
        end
      end
      S_TREP: begin
        if (sts.rep_full || sts.out_free) begin
          if (!sts.rep_full) begin
            cmd.emit      = 1'b1;
            cmd.emit_sel  = EMIT_REPORT;
            cmd.rep_count = 1'b1;
          end
          if (sts.idx_last) begin
            state_next = S_TDONE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_TCHK;
          end
        end
      end
      S_TDONE: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_DONE;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTH
  a_emit_into_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result emitted while the result register was still full");
  a_mod_wait: assert property (@(posedge clk) disable iff (rst)
    cmd.mod_start |=> (state == S_TMOD))
    else $error("remainder started without waiting for it");
`endif

endmodule

FILE: bench/tb.sv
// Self-checking bench for the retransmit tracking table: stimulus, predictor, driver and monitor.
`timescale 1ns / 100ps

module tb
  import rtt_pkg::*;
();

  // Register map: one 8-bit setting per 32-bit word.
  localparam logic [2:0] ADDR_TOTAL_TIMEOUT  = 3'd0;
  localparam logic [2:0] ADDR_RETRY_INTERVAL = 3'd4;

  // The block has no use for the fourth operation code and must stay silent.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int MAX_PAUSE    = 12;   // longest gap or stall drawn for one word
  localparam int DRAIN_CYCLES = 100;  // comfortably longer than a full tick sweep

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SEQ_W-1:0]  seq;
    logic [TYPE_W-1:0] dtype;
    logic [ADDR_W-1:0] addr;
    logic [GRP_W-1:0]  groups;
  } in_word_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq;
    logic [TYPE_W-1:0] dtype;
    logic [ADDR_W-1:0] addr;
    logic [GRP_W-1:0]  groups;
    logic [SLOT_W-1:0] slot;
    logic              found;
    logic              last;
  } out_word_t;

  // Every input of the block starts at a known value.
  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [2:0]        paddr        = '0;
  logic [31:0]       pwdata       = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid     = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   operation    = '0;
  logic [SEQ_W-1:0]  sequence_req = '0;
  logic [TYPE_W-1:0] send_type    = '0;
  logic [ADDR_W-1:0] send_addr    = '0;
  logic [GRP_W-1:0]  group_count  = '0;
  logic              out_valid;
  logic              out_ready    = 1'b0;
  logic [KIND_W-1:0] kind;
  logic [SEQ_W-1:0]  sequence_res;
  logic [TYPE_W-1:0] entry_type;
  logic [ADDR_W-1:0] entry_addr;
  logic [GRP_W-1:0]  entry_groups;
  logic [SLOT_W-1:0] slot;
  logic              found;
  logic              last;

  retransmit_tracking_table_top dut (.*);

  always #5 clk = ~clk;

  // Our own copy of the tracking table and of the two timing settings. It is
  // advanced once for every word the block accepts.
  logic [SEQ_W-1:0]  tbl_seq    [TABLE_ENTRIES];
  logic [TYPE_W-1:0] tbl_type   [TABLE_ENTRIES];
  logic [ADDR_W-1:0] tbl_addr   [TABLE_ENTRIES];
  logic [GRP_W-1:0]  tbl_groups [TABLE_ENTRIES];
  logic [TMR_W-1:0]  tbl_timer  [TABLE_ENTRIES];
  logic [SEQ_W-1:0]  seq_next;
  logic [7:0]        cfg_total_timeout;
  logic [7:0]        cfg_retry_interval;

  in_word_t  pending_words[$];  // words waiting to be offered to the block
  out_word_t due_results[$];    // results the block still owes, oldest first
  int        mismatches  = 0;

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Appends one expected result. Fields that carry no meaning for a result
  // are expected to read as zero.
  function automatic void post_result(input logic [KIND_W-1:0] k, input logic [SEQ_W-1:0] s,
                                      input int idx, input bit with_entry,
                                      input bit hit, input bit fin);
    out_word_t r;
    r      = '0;
    r.kind = k;
    r.seq  = s;
    if (with_entry) begin
      r.dtype  = tbl_type[idx];
      r.addr   = tbl_addr[idx];
      r.groups = tbl_groups[idx];
      r.slot   = SLOT_W'(idx);
    end
    r.found = hit;
    r.last  = fin;
    due_results.push_back(r);
  endfunction

  // Works out the results of one accepted word and updates the table copy.
  function automatic void table_apply(input in_word_t w);
    int hit;
    int reports;
    hit     = -1;
    reports = 0;
    case (w.op)
      OP_SEND: begin
        if (w.seq == '0) begin
          // A new transmission takes the highest-numbered free slot.
          for (int i = 0; i < TABLE_ENTRIES; i++)
            if (tbl_seq[i] == '0) hit = i;
          if (hit < 0) begin
            post_result(KIND_FULL, '0, 0, 1'b0, 1'b0, 1'b1);
          end else begin
            tbl_seq[hit]    = seq_next;
            tbl_type[hit]   = w.dtype;
            tbl_addr[hit]   = w.addr;
            tbl_groups[hit] = w.groups;
            tbl_timer[hit]  = cfg_total_timeout;
            seq_next        = (seq_next == '1) ? FIRST_SEQ : seq_next + 1'b1;
            post_result(KIND_NEW, tbl_seq[hit], hit, 1'b1, 1'b0, 1'b1);
          end
        end else if (w.seq >= FIRST_SEQ) begin
          post_result(KIND_RESEND, w.seq, 0, 1'b0, 1'b0, 1'b1);
        end else begin
          post_result(KIND_BAD_SEQ, w.seq, 0, 1'b0, 1'b0, 1'b1);
        end
      end
      OP_ACK: begin
        if (w.seq != '0)
          for (int i = 0; i < TABLE_ENTRIES; i++)
            if (tbl_seq[i] == w.seq) hit = i;
        if (hit < 0) begin
          post_result(KIND_ACK, w.seq, 0, 1'b0, 1'b0, 1'b1);
        end else begin
          post_result(KIND_ACK, w.seq, hit, 1'b1, 1'b1, 1'b1);
          tbl_seq[hit]    = '0;
          tbl_type[hit]   = '0;
          tbl_addr[hit]   = '0;
          tbl_groups[hit] = '0;
          tbl_timer[hit]  = '0;
        end
      end
      OP_TICK: begin
        // Expired entries (timer at zero) are left alone until acknowledged.
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (tbl_seq[i] >= FIRST_SEQ && tbl_timer[i] != '0) begin
            tbl_timer[i] = tbl_timer[i] - 1'b1;
            if (reports < MAX_REPORTS) begin
              if (tbl_timer[i] == '0) begin
                post_result(KIND_TIMEOUT, tbl_seq[i], i, 1'b1, 1'b0, 1'b0);
                reports++;
              end else if (cfg_retry_interval != '0 &&
                           tbl_timer[i] % cfg_retry_interval == '0) begin
                post_result(KIND_RETRY, tbl_seq[i], i, 1'b1, 1'b0, 1'b0);
                reports++;
              end
            end
          end
        end
        post_result(KIND_DONE, '0, 0, 1'b0, 1'b0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // Draws the idle cycles for one word. Now and then a calm stretch begins,
  // during which the side does not idle at all.
  function automatic int draw_pause(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 30);
    return $urandom_range(0, MAX_PAUSE);
  endfunction

  // Queues one word with a random payload; only sends store it, but the
  // other operations carry noise in those fields as well.
  function automatic void queue_word(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] s);
    in_word_t w;
    w.op     = op;
    w.seq    = s;
    w.dtype  = TYPE_W'($urandom());
    w.addr   = $urandom();
    w.groups = GRP_W'($urandom());
    pending_words.push_back(w);
  endfunction

  // Mostly well-formed traffic: new sends, acknowledgements aimed at the
  // sequences most recently handed out, and ticks. The rest is resends, bad
  // sequences, stray acknowledgements and the unused operation. This is
  // only called while the block is idle, so the table copy is current.
  task automatic queue_random_words(input int count);
    int issued;
    int pick;
    int guess;
    issued = 0;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        queue_word(OP_SEND, '0);
        issued++;
      end else if (pick < 68) begin
        guess = int'(seq_next) + issued - int'($urandom_range(1, 9));
        if (guess < int'(FIRST_SEQ)) guess += 65531;
        if (guess > 65535) guess -= 65531;
        queue_word(OP_ACK, SEQ_W'(guess));
      end else if (pick < 90) begin
        queue_word(OP_TICK, '0);
      end else if (pick < 94) begin
        queue_word(OP_SEND, SEQ_W'($urandom_range(5, 65535)));
      end else if (pick < 96) begin
        queue_word(OP_SEND, SEQ_W'($urandom_range(1, 4)));
      end else if (pick < 98) begin
        queue_word(OP_ACK, SEQ_W'($urandom()));
      end else begin
        queue_word(OP_UNUSED, SEQ_W'($urandom()));
      end
    end
  endtask

  // One register write (setup then access), then a read-back of the same
  // register. The table copy takes the new value on the write edge.
  task automatic program_register(input logic [2:0] addr, input logic [7:0] value);
    logic [31:0] seen;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_TOTAL_TIMEOUT) cfg_total_timeout = value;
    else cfg_retry_interval = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    seen = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field($sformatf("read-back of register at 0x%0h", addr), seen, {24'd0, value});
  endtask

  // The sender holds off until every word is through and every result is in,
  // then leaves room for a word that gives no result to finish inside.
  task automatic wait_for_idle();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || due_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Driver: offers the next queued word once the previous one has gone and
  // its gap has run out. The prediction is made on the accepting edge.
  in_word_t held;
  int       send_calm = 0;
  int       send_gap  = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) table_apply(held);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          held = pending_words.pop_front();
          operation    <= held.op;
          sequence_req <= held.seq;
          send_type    <= held.dtype;
          send_addr    <= held.addr;
          group_count  <= held.groups;
          in_valid     <= 1'b1;
          send_gap = draw_pause(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result taken is compared with the oldest one owed, and
  // the ready line is dropped for a random stall after each result.
  out_word_t owed;
  int        take_calm  = 0;
  int        take_stall = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result of kind %0d", kind));
        end else begin
          owed = due_results.pop_front();
          check_field("kind", kind, owed.kind);
          check_field("sequence_res", sequence_res, owed.seq);
          check_field("entry_type", entry_type, owed.dtype);
          check_field("entry_addr", entry_addr, owed.addr);
          check_field("entry_groups", entry_groups, owed.groups);
          check_field("slot", slot, owed.slot);
          check_field("found", found, owed.found);
          check_field("last", last, owed.last);
        end
        take_stall = draw_pause(take_calm);
      end
      if (take_stall > 0) begin
        take_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus and phase control.
  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_seq[i]    = '0;
      tbl_type[i]   = '0;
      tbl_addr[i]   = '0;
      tbl_groups[i] = '0;
      tbl_timer[i]  = '0;
    end
    seq_next           = FIRST_SEQ;
    cfg_total_timeout  = 8'd20;
    cfg_retry_interval = 8'd5;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset settings. A tick on an empty table gives
    // only its closing word; then sends with all-zero and all-one payloads,
    // resends at both ends of the range, the lowest and highest bad sequences,
    // unmatched acknowledgements, and the unused operation.
    queue_word(OP_TICK, '0);
    pending_words.push_back('{OP_SEND, '0, '0, '0, '0});
    pending_words.push_back('{OP_SEND, '0, '1, '1, '1});
    queue_word(OP_SEND, FIRST_SEQ);
    queue_word(OP_SEND, '1);
    queue_word(OP_SEND, SEQ_W'(1));
    queue_word(OP_SEND, SEQ_W'(4));
    queue_word(OP_ACK, '0);
    queue_word(OP_ACK, '1);
    pending_words.push_back('{OP_UNUSED, '1, '1, '1, '1});
    // Six sends fill the table and a seventh finds it full. Freeing the
    // second entry leaves a single hole, and a tick merely counts down.
    repeat (7) queue_word(OP_SEND, '0);
    queue_word(OP_ACK, SEQ_W'(6));
    queue_word(OP_TICK, '0);
    wait_for_idle();

    // Short timeout and a retry every second: the refilled table reports
    // from every slot on one tick, and the newest entry runs out after
    // three ticks, stays silent on the fourth, and is acknowledged late.
    program_register(ADDR_TOTAL_TIMEOUT, 8'd3);
    program_register(ADDR_RETRY_INTERVAL, 8'd1);
    queue_word(OP_SEND, '0);
    repeat (4) queue_word(OP_TICK, '0);
    queue_word(OP_ACK, SEQ_W'(13));
    wait_for_idle();

    // Random traffic under a range of settings, the extremes among them.
    // Zero for either setting means no timeout or no retries respectively.
    program_register(ADDR_TOTAL_TIMEOUT, 8'd7);
    program_register(ADDR_RETRY_INTERVAL, 8'd2);
    queue_random_words(45);
    wait_for_idle();

    program_register(ADDR_TOTAL_TIMEOUT, 8'd255);
    program_register(ADDR_RETRY_INTERVAL, 8'd255);
    queue_random_words(45);
    wait_for_idle();

    program_register(ADDR_TOTAL_TIMEOUT, 8'd0);
    program_register(ADDR_RETRY_INTERVAL, 8'd0);
    queue_random_words(45);
    wait_for_idle();

    program_register(ADDR_TOTAL_TIMEOUT, 8'd1);
    program_register(ADDR_RETRY_INTERVAL, 8'd1);
    queue_random_words(45);
    wait_for_idle();

    program_register(ADDR_TOTAL_TIMEOUT, 8'($urandom_range(1, 24)));
    program_register(ADDR_RETRY_INTERVAL, 8'($urandom_range(1, 8)));
    queue_random_words(45);
    wait_for_idle();

    // A last stretch of random traffic at ordinary settings.
    program_register(ADDR_TOTAL_TIMEOUT, 8'd12);
    program_register(ADDR_RETRY_INTERVAL, 8'd3);
    queue_random_words(30);
    wait_for_idle();

    if (mismatches == 0) begin
      $display("PASS retransmit_tracking_table_top");
    end else begin
      $display("FAIL retransmit_tracking_table_top");
    end
    $finish;
  end

  // Watchdog: even with every word and every result stalled as long as the
  // bench allows, a run finishes before this limit, so reaching it means
  // the run has hung.
  initial begin
    #4_000_000;
    $display("FAIL retransmit_tracking_table_top");
    $finish;
  end

endmodule
